@@ sv/greedy_box_suppression_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for greedy_box_suppression
// Concurrent check wrappers that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef GREEDY_BOX_SUPPRESSION_MACROS_SVH
`define GREEDY_BOX_SUPPRESSION_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define GBS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("greedy_box_suppression: property violated");
// Condition must never be seen at a clock edge outside reset.
`define GBS_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("greedy_box_suppression: forbidden condition seen");
`else
`define GBS_ASSERT(lbl, clk, rst_n, prop)
`define GBS_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

@@ sv/gbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types, constants and helpers of the box suppression block.
// ----------------------------------------------------------------------------
package gbs_pkg;

	localparam int KEEP_DEPTH_DEF  = 128;
	localparam int COORD_BITS_DEF  = 16;
	// Widest coordinate the helpers below support.
	localparam int COORD_MAX       = 24;

	localparam int          THR_W     = 16;
	localparam logic [15:0] THR_RESET = 16'd13107;

	// Configuration port: byte address, one 32-bit word per register.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_IOU_THRESHOLD = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPAN,
		ST_AREA,
		ST_SCAN,
		ST_FIN
	} state_t;

	// Status of the overlap test pipeline toward the sequencer.
	typedef struct packed {
		logic hit;
		logic busy;
	} iou_stat_t;

	// Extent from lo to hi, clamped at zero when the edge pair is inverted.
	function automatic logic [COORD_MAX-1:0] span_f(input logic signed [COORD_MAX:0] lo,
		input logic signed [COORD_MAX:0] hi);
		logic signed [COORD_MAX+1:0] d;
		d = (COORD_MAX+2)'(hi) - (COORD_MAX+2)'(lo);
		if (d > 0) begin
			span_f = d[COORD_MAX-1:0];
		end else begin
			span_f = '0;
		end
	endfunction

endpackage

@@ sv/gbs_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_store
// Kept box memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gbs_store #(
	parameter int DEPTH  = gbs_pkg::KEEP_DEPTH_DEF,
	parameter int DATA_W = 4 * gbs_pkg::COORD_BITS_DEF,
	parameter int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_addr,
	output logic [DATA_W-1:0] rd_data,
	output logic              rd_valid
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic              rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// The valid flag rises in the cycle after each read, matching the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= rd_en;
		end
	end

	assign rd_data  = rd_data_q;
	assign rd_valid = rd_valid_q;

endmodule

@@ sv/gbs_iou.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_iou
// Four-stage overlap test of one stored box against the current box.
// ----------------------------------------------------------------------------
module gbs_iou #(
	parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [4*COORD_BITS-1:0]   kept_box,
	input  logic [4*COORD_BITS-1:0]   cur_box,
	input  logic [2*COORD_BITS-1:0]   cur_area,
	input  logic [gbs_pkg::THR_W-1:0] thr,
	output gbs_pkg::iou_stat_t        stat
);

	import gbs_pkg::*;

	localparam int CB     = COORD_BITS;
	localparam int AREA_W = 2 * CB;
	localparam int UNI_W  = AREA_W + 1;
	localparam int PROD_W = UNI_W + THR_W;

	logic signed [CB-1:0] kx0, ky0, kx1, ky1;
	logic signed [CB-1:0] cx0, cy0, cx1, cy1;
	logic signed [CB-1:0] ix0, iy0, ix1, iy1;

	logic [CB-1:0]     iw_s1, ih_s1, kw_s1, kh_s1;
	logic [AREA_W-1:0] inter_s2, karea_s2;
	logic [AREA_W-1:0] inter_s3;
	logic [UNI_W-1:0]  uni_s3;
	logic [AREA_W-1:0] inter_s4;
	logic [PROD_W-1:0] prod_s4;
	logic [PROD_W-1:0] lhs;
	logic              v_s1, v_s2, v_s3, v_s4;

	assign kx0 = $signed(kept_box[4*CB-1:3*CB]);
	assign ky0 = $signed(kept_box[3*CB-1:2*CB]);
	assign kx1 = $signed(kept_box[2*CB-1:CB]);
	assign ky1 = $signed(kept_box[CB-1:0]);
	assign cx0 = $signed(cur_box[4*CB-1:3*CB]);
	assign cy0 = $signed(cur_box[3*CB-1:2*CB]);
	assign cx1 = $signed(cur_box[2*CB-1:CB]);
	assign cy1 = $signed(cur_box[CB-1:0]);

	always_comb begin
		ix0 = (kx0 > cx0) ? kx0 : cx0;
		iy0 = (ky0 > cy0) ? ky0 : cy0;
		ix1 = (kx1 < cx1) ? kx1 : cx1;
		iy1 = (ky1 < cy1) ? ky1 : cy1;
	end

	always_ff @(posedge clk) begin
		iw_s1 <= CB'(span_f((COORD_MAX+1)'(ix0), (COORD_MAX+1)'(ix1)));
		ih_s1 <= CB'(span_f((COORD_MAX+1)'(iy0), (COORD_MAX+1)'(iy1)));
		kw_s1 <= CB'(span_f((COORD_MAX+1)'(kx0), (COORD_MAX+1)'(kx1)));
		kh_s1 <= CB'(span_f((COORD_MAX+1)'(ky0), (COORD_MAX+1)'(ky1)));

		inter_s2 <= AREA_W'(iw_s1) * AREA_W'(ih_s1);
		karea_s2 <= AREA_W'(kw_s1) * AREA_W'(kh_s1);

		// The intersection never exceeds either area, so the union cannot go negative.
		inter_s3 <= inter_s2;
		uni_s3   <= UNI_W'(karea_s2) + UNI_W'(cur_area) - UNI_W'(inter_s2);

		inter_s4 <= inter_s3;
		prod_s4  <= PROD_W'(thr) * PROD_W'(uni_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// An empty union means an empty intersection, and 0 > 0 never suppresses.
	assign lhs       = {1'b0, inter_s4, {THR_W{1'b0}}};
	assign stat.hit  = v_s4 && (lhs > prod_s4);
	assign stat.busy = in_valid || v_s1 || v_s2 || v_s3 || v_s4;

endmodule

@@ sv/greedy_box_suppression.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy IoU suppression of score-ordered boxes against a kept-box memory.
// ----------------------------------------------------------------------------
// Usage:
//   Boxes enter on the in_valid / in_stall channel, one beat per box, in
//   descending score order. Each box yields exactly one result beat on the
//   out_valid / out_stall channel with its tag and the keep, truncated and
//   set_done flags. The box marked last closes the set and empties the store.
//   Flow: with N boxes kept in the set so far, an accepted box passes the span
//   and area states, then a scan of the N kept boxes, one read per cycle, into
//   the four-stage overlap pipeline; a suppressing hit ends the scan early.
//   in_stall stays high from acceptance until the result is loaded into the
//   output register, so the next box is taken while a result still waits.
//   If the receiver stalls, the result register holds and a finished box waits
//   in its final state until the register frees.
//   Reset clears the kept count, the control state and restores iou_threshold
//   to 0.2; the memory contents are not cleared, since only entries below the
//   kept count are ever read. iou_threshold is written at APB address 0 while
//   the block is idle.
// ----------------------------------------------------------------------------
`include "greedy_box_suppression_macros.svh"

module greedy_box_suppression #(
	parameter int KEEP_DEPTH = gbs_pkg::KEEP_DEPTH_DEF,
	parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gbs_pkg::ADDR_W-1:0] paddr,
	input  logic [gbs_pkg::DATA_W-1:0] pwdata,
	output logic [gbs_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	// Box channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [15:0]                box_id,
	input  logic signed [15:0]         x_min,
	input  logic signed [15:0]         y_min,
	input  logic signed [15:0]         x_max,
	input  logic signed [15:0]         y_max,
	input  logic                       last,
	// Result channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [15:0]                result_id,
	output logic                       keep,
	output logic                       truncated,
	output logic                       set_done
);

	import gbs_pkg::*;

	localparam int CB     = COORD_BITS;
	localparam int AREA_W = 2 * CB;
	localparam int CNT_W  = $clog2(KEEP_DEPTH + 1);
	localparam int IDX_W  = (KEEP_DEPTH > 1) ? $clog2(KEEP_DEPTH) : 1;

	state_t state_q, state_d;

	logic [THR_W-1:0]     thr_q;
	logic signed [CB-1:0] cx0, cy0, cx1, cy1;
	logic signed [CB-1:0] cx0_q, cy0_q, cx1_q, cy1_q;
	logic [15:0]          box_id_q;
	logic                 last_q;
	logic [CB-1:0]        cw_q, ch_q;
	logic [AREA_W-1:0]    carea_q;
	logic [4*CB-1:0]      cur_box;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic             hit_q;

	logic             out_valid_q;
	logic [15:0]      result_id_q;
	logic             keep_q, truncated_q, set_done_q;

	logic             in_accept, out_free, issue_en, scan_end, fin_load;
	logic             room, keep_now, trunc_now;
	logic             wr_en, cfg_wr;
	logic [4*CB-1:0]  rd_data;
	logic             rd_valid;
	iou_stat_t        stat;

	// Coordinates are reduced to COORD_BITS, or sign-extended when COORD_BITS is wider than 16.
	if (COORD_BITS <= 16) begin : g_narrow
		assign cx0 = $signed(x_min[COORD_BITS-1:0]);
		assign cy0 = $signed(y_min[COORD_BITS-1:0]);
		assign cx1 = $signed(x_max[COORD_BITS-1:0]);
		assign cy1 = $signed(y_max[COORD_BITS-1:0]);
	end else begin : g_wide
		assign cx0 = COORD_BITS'(x_min);
		assign cy0 = COORD_BITS'(y_min);
		assign cx1 = COORD_BITS'(x_max);
		assign cy1 = COORD_BITS'(y_max);
	end

	assign cur_box = {cx0_q, cy0_q, cx1_q, cy1_q};

	// ---- Configuration port -------------------------------------------------
	// Registers are decoded by word index; byte lanes inside a word are ignored.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr && (paddr[2] == REG_IOU_THRESHOLD)) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_IOU_THRESHOLD) begin
			prdata = DATA_W'(thr_q);
		end
	end

	// ---- Sequencer ----------------------------------------------------------
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign room      = (count_q < CNT_W'(KEEP_DEPTH));
	assign keep_now  = !hit_q && room;
	assign trunc_now = !hit_q && !room;

	// Reads stop at the first hit; entries already in flight drain unused.
	assign issue_en = (state_q == ST_SCAN) && !hit_q && !stat.hit && (idx_q < count_q);
	assign scan_end = (state_q == ST_SCAN) && !issue_en && !stat.busy;
	assign fin_load = (state_q == ST_FIN) && out_free;
	assign wr_en    = fin_load && keep_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = ST_SPAN;
				end
			end
			ST_SPAN: state_d = ST_AREA;
			ST_AREA: state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Current box and its area, held for the whole scan.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cx0_q    <= cx0;
			cy0_q    <= cy0;
			cx1_q    <= cx1;
			cy1_q    <= cy1;
			box_id_q <= box_id;
			last_q   <= last;
		end
		if (state_q == ST_SPAN) begin
			cw_q <= CB'(span_f((COORD_MAX+1)'(cx0_q), (COORD_MAX+1)'(cx1_q)));
			ch_q <= CB'(span_f((COORD_MAX+1)'(cy0_q), (COORD_MAX+1)'(cy1_q)));
		end
		if (state_q == ST_AREA) begin
			carea_q <= AREA_W'(cw_q) * AREA_W'(ch_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (in_accept) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (issue_en) begin
					idx_q <= idx_q + 1'b1;
				end
				if ((state_q == ST_SCAN) && stat.hit) begin
					hit_q <= 1'b1;
				end
			end
			// The last box of a set empties the store after its result.
			if (fin_load) begin
				if (last_q) begin
					count_q <= '0;
				end else if (keep_now) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// ---- Result register ----------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			result_id_q <= box_id_q;
			keep_q      <= keep_now;
			truncated_q <= trunc_now;
			set_done_q  <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign result_id = result_id_q;
	assign keep      = keep_q;
	assign truncated = truncated_q;
	assign set_done  = set_done_q;

	// ---- Datapath -----------------------------------------------------------
	gbs_store #(
		.DEPTH  (KEEP_DEPTH),
		.DATA_W (4 * CB),
		.IDX_W  (IDX_W)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (count_q[IDX_W-1:0]),
		.wr_data  (cur_box),
		.rd_en    (issue_en),
		.rd_addr  (idx_q[IDX_W-1:0]),
		.rd_data  (rd_data),
		.rd_valid (rd_valid)
	);

	gbs_iou #(
		.COORD_BITS (CB)
	) u_iou (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rd_valid),
		.kept_box (rd_data),
		.cur_box  (cur_box),
		.cur_area (carea_q),
		.thr      (thr_q),
		.stat     (stat)
	);

	// ---- Checks -------------------------------------------------------------
	`GBS_NEVER(a_flags_exclusive, clk, arst_n, out_valid_q && keep_q && truncated_q)
	`GBS_NEVER(a_no_write_when_full, clk, arst_n, wr_en && !room)
	`GBS_ASSERT(a_last_clears_store, clk, arst_n, fin_load && last_q |=> count_q == '0)
	`GBS_ASSERT(a_busy_after_accept, clk, arst_n, in_accept |=> in_stall)

endmodule

@@ sim/tb_greedy_box_suppression.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greedy_box_suppression
// Self-checking bench for the greedy box suppression block. A queue of boxes
// feeds a clocked driver, and a clocked monitor compares every result beat
// with the verdict of a built-in suppression predictor. The run covers
// directed corner boxes, clustered and noisy random sets, sets that overflow
// the kept-box store, and several IoU thresholds set over the APB port.
// ----------------------------------------------------------------------------
module tb_greedy_box_suppression;

	localparam int KEEP         = gbs_pkg::KEEP_DEPTH_DEF;
	localparam int GAP_MAX      = 16;
	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_BOXES = 2000;
	localparam int PHASES       = 8;
	localparam int REPORT_MAX   = 100;
	// Byte address of the threshold register, one 32-bit word per register.
	localparam logic [gbs_pkg::ADDR_W-1:0] THR_ADDR =
		gbs_pkg::ADDR_W'(4 * gbs_pkg::REG_IOU_THRESHOLD);

	// One box beat as it stands on the input ports.
	typedef struct packed {
		logic [15:0] id;
		logic [15:0] x0;
		logic [15:0] y0;
		logic [15:0] x1;
		logic [15:0] y1;
		logic        fin;
	} box_beat_t;

	// One result beat.
	typedef struct packed {
		logic [15:0] id;
		logic        keep;
		logic        truncated;
		logic        set_done;
	} verdict_t;

	// Corners of a kept box, sign-extended so the arithmetic never wraps.
	typedef struct {
		longint x0;
		longint y0;
		longint x1;
		longint y1;
	} corners_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       psel      = 1'b0;
	logic                       penable   = 1'b0;
	logic                       pwrite    = 1'b0;
	logic [gbs_pkg::ADDR_W-1:0] paddr     = '0;
	logic [gbs_pkg::DATA_W-1:0] pwdata    = '0;
	logic [gbs_pkg::DATA_W-1:0] prdata;
	logic                       pready;
	logic                       in_valid  = 1'b0;
	logic                       in_stall;
	logic [15:0]                box_id    = '0;
	logic signed [15:0]         x_min     = '0;
	logic signed [15:0]         y_min     = '0;
	logic signed [15:0]         x_max     = '0;
	logic signed [15:0]         y_max     = '0;
	logic                       last      = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [15:0]                result_id;
	logic                       keep;
	logic                       truncated;
	logic                       set_done;

	// Boxes waiting to be driven, and verdicts waiting for their result beat.
	box_beat_t box_queue[$];
	verdict_t  verdict_queue[$];

	// Predictor state: its own copy of the kept-box store and the threshold.
	corners_t    kept_store[KEEP];
	int unsigned kept_n    = 0;
	logic [15:0] thr_model = gbs_pkg::THR_RESET;

	// When set, neither side inserts gaps or stalls.
	bit steady = 1'b0;

	int gap_left    = 0;
	int stall_left  = 0;
	int quiet       = 0;
	int errors      = 0;
	int boxes_in    = 0;
	int kept_seen   = 0;
	int supp_seen   = 0;
	int trunc_seen  = 0;
	int sets_seen   = 0;
	int thr_settings = 0;

	greedy_box_suppression #(
		.KEEP_DEPTH(gbs_pkg::KEEP_DEPTH_DEF),
		.COORD_BITS(gbs_pkg::COORD_BITS_DEF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.box_id(box_id),
		.x_min(x_min),
		.y_min(y_min),
		.x_max(x_max),
		.y_max(y_max),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_id(result_id),
		.keep(keep),
		.truncated(truncated),
		.set_done(set_done)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Suppression predictor
	// ------------------------------------------------------------------------

	// Extent of an edge pair; an inverted pair has no extent at all.
	function automatic longint extent(input longint lo, input longint hi);
		return (hi > lo) ? hi - lo : 0;
	endfunction

	// True when the IoU of the two boxes is strictly above the threshold.
	// The test is cross-multiplied, so no division and no rounding enter.
	// A union of zero (two boxes without area) never suppresses.
	function automatic bit iou_above(input corners_t a, input corners_t b,
		input longint thr);
		longint inter;
		longint joint;
		inter = extent(a.x0 > b.x0 ? a.x0 : b.x0, a.x1 < b.x1 ? a.x1 : b.x1) *
			extent(a.y0 > b.y0 ? a.y0 : b.y0, a.y1 < b.y1 ? a.y1 : b.y1);
		joint = extent(a.x0, a.x1) * extent(a.y0, a.y1) +
			extent(b.x0, b.x1) * extent(b.y0, b.y1) - inter;
		if (joint == 0) begin
			return 1'b0;
		end
		return (inter * 65536) > (thr * joint);
	endfunction

	// Verdict for one accepted box. A box survives unless a kept box of the
	// same set overlaps it too much. A survivor is stored while there is
	// room; once the store is full it is flagged truncated and not stored,
	// so it never suppresses anything later. The last box empties the store
	// after its own verdict.
	function automatic verdict_t judge_box(input box_beat_t b);
		corners_t cur;
		bit       hit;
		verdict_t v;
		cur.x0 = longint'($signed(b.x0));
		cur.y0 = longint'($signed(b.y0));
		cur.x1 = longint'($signed(b.x1));
		cur.y1 = longint'($signed(b.y1));
		hit = 1'b0;
		for (int i = 0; i < kept_n; i++) begin
			if (!hit && iou_above(kept_store[i], cur, longint'(thr_model))) begin
				hit = 1'b1;
			end
		end
		v.id        = b.id;
		v.keep      = 1'b0;
		v.truncated = 1'b0;
		v.set_done  = b.fin;
		if (!hit) begin
			if (kept_n < KEEP) begin
				kept_store[kept_n] = cur;
				kept_n++;
				v.keep = 1'b1;
			end else begin
				v.truncated = 1'b1;
			end
		end
		if (b.fin) begin
			kept_n = 0;
		end
		return v;
	endfunction

	// ------------------------------------------------------------------------
	// Driver: presents queued boxes one beat at a time. After each box it
	// waits a drawn number of cycles before the next one, so gaps land on
	// every phase of the block's scan. A stalled beat is held unchanged.
	// The verdict is worked out at the edge at which the beat is accepted.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		box_beat_t pick;
		verdict_t  fresh;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				fresh = judge_box('{box_id, x_min, y_min, x_max, y_max, last});
				verdict_queue = {verdict_queue, fresh};
				boxes_in++;
			end
			if (in_valid && in_stall) begin
				// Beat stalled: payload and valid stay as they are.
			end else if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (box_queue.size() != 0) begin
				pick = box_queue.pop_front();
				box_id   <= pick.id;
				x_min    <= pick.x0;
				y_min    <= pick.y0;
				x_max    <= pick.x1;
				y_max    <= pick.y1;
				last     <= pick.fin;
				in_valid <= 1'b1;
				gap_left <= steady ? 0 : $urandom_range(0, GAP_MAX);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: takes result beats and checks them field by field against the
	// oldest waiting verdict. After each beat it raises the stall for a drawn
	// number of cycles, so results also back up into the block.
	// ------------------------------------------------------------------------
	task automatic compare_field(input string what, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= REPORT_MAX) begin
				$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what,
					want, got);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		int       hold;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && !out_stall) begin
			if (verdict_queue.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX) begin
					$display("%0t ns: result beat with no box pending, expected none, got id %0h",
						$time, result_id);
				end
			end else begin
				want = verdict_queue.pop_front();
				compare_field("result_id", want.id, result_id);
				compare_field("keep", want.keep, keep);
				compare_field("truncated", want.truncated, truncated);
				compare_field("set_done", want.set_done, set_done);
				if (want.keep) begin
					kept_seen++;
				end else if (want.truncated) begin
					trunc_seen++;
				end else begin
					supp_seen++;
				end
				if (want.set_done) begin
					sets_seen++;
				end
			end
			hold = steady ? 0 : $urandom_range(0, GAP_MAX);
			stall_left <= hold;
			out_stall  <= (hold != 0);
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_left <= 0;
			out_stall  <= 1'b0;
		end
	end

	// Watchdog: the run is stuck if no beat moves on any port for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("%0t ns: timeout, no beat for %0d cycles", $time, QUIET_LIMIT);
				$display("TB_ERROR");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic logic [15:0] clamp16(input int v);
		if (v > 32767) begin
			return 16'h7FFF;
		end
		if (v < -32768) begin
			return 16'h8000;
		end
		return v[15:0];
	endfunction

	task automatic queue_box(input logic [15:0] id, input int x0, input int y0,
		input int x1, input int y1, input bit fin);
		box_beat_t b;
		b.id  = id;
		b.x0  = clamp16(x0);
		b.y0  = clamp16(y0);
		b.x1  = clamp16(x1);
		b.y1  = clamp16(y1);
		b.fin = fin;
		box_queue = {box_queue, b};
	endtask

	// Waits until every queued box has been taken and every verdict has
	// been matched by a result, then a little longer. The block is idle
	// afterwards, since each box yields exactly one result.
	task automatic drain;
		do begin
			@(negedge clk);
		end while (box_queue.size() != 0 || in_valid || verdict_queue.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// One APB transfer: a setup cycle, then the access cycle until pready.
	task automatic apb_xfer(input bit wr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= THR_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_threshold(input logic [15:0] want);
		logic [31:0] rd;
		apb_xfer(1'b0, 32'd0, rd);
		if (rd[15:0] !== want) begin
			errors++;
			$display("%0t ns: iou_threshold readback mismatch, expected %0h, got %0h",
				$time, want, rd[15:0]);
		end
	endtask

	task automatic set_threshold(input logic [15:0] v);
		logic [31:0] rd;
		apb_xfer(1'b1, {16'd0, v}, rd);
		thr_model = v;
		thr_settings++;
		check_threshold(v);
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [15:0] thr_plan[PHASES];
		int          phase;
		int          made;
		int          set_len;
		int          k;
		int          kind;
		int          pick_c;
		int          w;
		int          h;
		int          d;
		int          grid_pos;
		int          bx;
		int          by;
		int          cx[3];
		int          cy[3];
		int          px0;
		int          py0;
		int          px1;
		int          py1;
		bit          close_set;

		px0 = 0;
		py0 = 0;
		px1 = 0;
		py1 = 0;

		// Asynchronous reset, released away from the clock edge.
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The threshold must come out of reset at 0.2.
		check_threshold(gbs_pkg::THR_RESET);
		thr_settings++;
		@(negedge clk);

		// Directed set at the reset threshold. The first box is kept; an
		// identical copy is suppressed (IoU of one). The full-range box
		// overlaps it only slightly and is kept. The two boxes with both edge
		// pairs inverted have no area. The point box has no area either, so
		// against them the intersection is empty and nothing is suppressed.
		// The second full-range box is an exact copy, and the thin box has
		// IoU 0.25 against the first one; both are suppressed.
		queue_box(16'h0000, 0, 0, 8192, 8192, 1'b0);
		queue_box(16'hFFFF, 0, 0, 8192, 8192, 1'b0);
		queue_box(16'h8001, -32768, -32768, 32767, 32767, 1'b0);
		queue_box(16'h7FFE, 32767, 32767, -32768, -32768, 1'b0);
		queue_box(16'h0101, 100, 100, -100, 50, 1'b0);
		queue_box(16'h0202, 5, 5, 5, 5, 1'b0);
		queue_box(16'h0303, -32768, -32768, 32767, 32767, 1'b0);
		queue_box(16'h0404, 0, 0, 8192, 2048, 1'b1);
		// The last box emptied the store, so the same box is kept again.
		queue_box(16'h0505, 0, 0, 8192, 8192, 1'b1);
		drain();

		// At a threshold of one half an IoU of exactly one half must not
		// suppress, since the test is strict; an exact copy still does.
		set_threshold(16'd32768);
		queue_box(16'h0606, 0, 0, 100, 100, 1'b0);
		queue_box(16'h0707, 0, 0, 50, 100, 1'b0);
		queue_box(16'h0808, 0, 0, 100, 100, 1'b1);
		drain();

		// Random phases, each at its own threshold. The extremes come first;
		// the threshold of zero suppresses on any overlap, the largest one only
		// on exact or nearly exact copies. Every third phase runs without idling.
		thr_plan[0] = 16'd0;
		thr_plan[1] = 16'd65535;
		thr_plan[2] = gbs_pkg::THR_RESET;
		thr_plan[3] = 16'd1;
		for (phase = 4; phase < PHASES; phase++) begin
			thr_plan[phase] = 16'($urandom_range(0, 65535));
		end

		for (phase = 0; phase < PHASES; phase++) begin
			set_threshold(thr_plan[phase]);
			steady <= (phase % 3 == 2);
			@(negedge clk);
			made = 0;
			while (made < RANDOM_BOXES / PHASES) begin
				if ((phase % 3 == 1 && made == 0) || $urandom_range(0, 29) == 0) begin
					// Store overflow: disjoint boxes on a 12 x 12 grid all
					// survive, so after KEEP of them the rest are truncated.
					// A few exact copies of the previous box are mixed in;
					// a copy of a stored box is suppressed, a copy of a
					// truncated one is truncated again.
					set_len = $urandom_range(KEEP + 8, KEEP + 15);
					grid_pos = 0;
					for (k = 0; k < set_len; k++) begin
						if (k != 0 && (grid_pos >= 144 || $urandom_range(0, 19) == 0)) begin
							queue_box(16'($urandom_range(0, 65535)), px0, py0, px1, py1,
								k == set_len - 1);
						end else begin
							bx  = -32400 + (grid_pos % 12) * 5400;
							by  = -32400 + (grid_pos / 12) * 5400;
							px0 = bx + int'($urandom_range(0, 1200));
							px1 = px0 + int'($urandom_range(0, 3800));
							py0 = by + int'($urandom_range(0, 1200));
							py1 = py0 + int'($urandom_range(0, 3800));
							grid_pos++;
							queue_box(16'($urandom_range(0, 65535)), px0, py0, px1, py1,
								k == set_len - 1);
						end
					end
					made += set_len;
				end else begin
					// Ordinary set: boxes jittered around three centers so
					// that overlaps near the threshold are common, mixed with
					// fully random corners and slightly shifted copies. The
					// set that fills the phase is sometimes left open, so it
					// carries on under the next threshold.
					set_len = $urandom_range(1, 24);
					close_set = !(made + set_len >= RANDOM_BOXES / PHASES &&
						$urandom_range(0, 2) == 0);
					for (k = 0; k < 3; k++) begin
						cx[k] = int'($urandom_range(0, 56000)) - 28000;
						cy[k] = int'($urandom_range(0, 56000)) - 28000;
					end
					for (k = 0; k < set_len; k++) begin
						kind = $urandom_range(0, 9);
						if (kind < 6) begin
							pick_c = $urandom_range(0, 2);
							w   = $urandom_range(64, 9000);
							h   = $urandom_range(64, 9000);
							px0 = cx[pick_c] - w / 2 + int'($urandom_range(0, w / 2)) - w / 4;
							py0 = cy[pick_c] - h / 2 + int'($urandom_range(0, h / 2)) - h / 4;
							px1 = px0 + w;
							py1 = py0 + h;
						end else if (kind < 8) begin
							px0 = int'($urandom_range(0, 65535)) - 32768;
							py0 = int'($urandom_range(0, 65535)) - 32768;
							px1 = int'($urandom_range(0, 65535)) - 32768;
							py1 = int'($urandom_range(0, 65535)) - 32768;
						end else begin
							d   = int'($urandom_range(0, 64)) - 32;
							px0 = px0 + d;
							px1 = px1 + d;
							d   = int'($urandom_range(0, 64)) - 32;
							py0 = py0 + d;
							py1 = py1 + d;
						end
						queue_box(16'($urandom_range(0, 65535)), px0, py0, px1, py1,
							close_set && k == set_len - 1);
					end
					made += set_len;
				end
			end
			// Hold off the sender until every verdict has been matched.
			drain();
		end

		// Let any stray result beat show up before the verdict.
		repeat (300) @(posedge clk);
		if (verdict_queue.size() != 0) begin
			errors++;
			$display("%0t ns: %0d results never arrived", $time, verdict_queue.size());
		end

		$display("Run covered %0d boxes in %0d closed sets over %0d threshold settings.",
			boxes_in, sets_seen, thr_settings);
		$display("Verdicts: %0d kept, %0d suppressed, %0d truncated; %0d mismatches.",
			kept_seen, supp_seen, trunc_seen, errors);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ greedy_box_suppression.f @@
+incdir+sv
sv/gbs_pkg.sv
sv/gbs_store.sv
sv/gbs_iou.sv
sv/greedy_box_suppression.sv
sim/tb_greedy_box_suppression.sv
